// ----- rtl/pisp_pkg.sv -----
// Package: shared types, constants and sine lookup for the PI sine PWM control block.
package pisp_pkg;

    localparam int RING_DEPTH  = 256;
    localparam int SAMPLE_BITS = 12;
    localparam int SINE_SHIFT  = 9;

    localparam int PH_BITS   = $clog2(RING_DEPTH);
    localparam int SUM_BITS  = SAMPLE_BITS + PH_BITS;
    localparam int ERR_BITS  = ((SAMPLE_BITS + 4 > 16) ? SAMPLE_BITS + 4 : 16) + 2;
    localparam int MULA_BITS = ERR_BITS + 1;
    localparam int MULB_BITS = 17;
    localparam int PROD_BITS = MULA_BITS + MULB_BITS;
    localparam int INTEG_BITS = 48;
    localparam int SH_DN = (PH_BITS >= 8) ? PH_BITS - 8 : 0;
    localparam int SH_UP = (PH_BITS >= 8) ? 0 : 8 - PH_BITS;

    // Configuration register indexes
    localparam logic [2:0] REG_SETPOINT = 3'd0;
    localparam logic [2:0] REG_PROP     = 3'd1;
    localparam logic [2:0] REG_INT      = 3'd2;
    localparam logic [2:0] REG_TRIP     = 3'd3;
    localparam logic [2:0] REG_PERIOD   = 3'd4;

    localparam logic [15:0] SETPOINT_RST = 16'd31283;
    localparam logic [15:0] PROP_RST     = 16'd3277;
    localparam logic [15:0] INT_RST      = 16'd33;
    localparam logic [11:0] TRIP_RST     = 12'd3583;
    localparam logic [14:0] PERIOD_RST   = 15'd1500;
    localparam logic [14:0] HOLD_RST     = 15'd1500;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] adc_sample;
        logic                   adc_switch;
        logic                   pwm_switch;
    } in_t;

    typedef struct packed {
        logic [14:0] compare_one;
        logic [14:0] compare_two;
        logic        drive_enable;
        logic        tripped;
        logic        led_measure;
        logic        led_drive;
    } out_t;

    localparam logic [9:0] QSINE [0:64] = '{
        10'd0,   10'd13,  10'd25,  10'd38,  10'd50,  10'd63,  10'd75,  10'd88,
        10'd100, 10'd112, 10'd124, 10'd137, 10'd149, 10'd161, 10'd172, 10'd184,
        10'd196, 10'd207, 10'd219, 10'd230, 10'd241, 10'd252, 10'd263, 10'd274,
        10'd284, 10'd295, 10'd305, 10'd315, 10'd325, 10'd334, 10'd344, 10'd353,
        10'd362, 10'd371, 10'd379, 10'd388, 10'd396, 10'd404, 10'd411, 10'd419,
        10'd426, 10'd433, 10'd439, 10'd445, 10'd452, 10'd457, 10'd463, 10'd468,
        10'd473, 10'd478, 10'd482, 10'd486, 10'd490, 10'd493, 10'd497, 10'd500,
        10'd502, 10'd504, 10'd506, 10'd508, 10'd510, 10'd511, 10'd511, 10'd512,
        10'd512
    };

    // Map a ring position onto the 256-step sine table
    function automatic logic [7:0] sine_index(input logic [PH_BITS-1:0] ph);
        logic [31:0] t;
        t = 32'(ph);
        t = (t >> SH_DN) << SH_UP;
        return t[7:0];
    endfunction

    // Full-wave sine from the quarter table, amplitude 512
    function automatic logic signed [10:0] sine_at(input logic [7:0] i);
        logic [6:0]  h;
        logic [9:0]  v;
        logic [7:0]  m;
        h = i[6:0];
        m = 8'd128 - {1'b0, h};
        v = (h <= 7'd64) ? QSINE[h] : QSINE[m[6:0]];
        return i[7] ? -$signed({1'b0, v}) : $signed({1'b0, v});
    endfunction

endpackage

// ----- rtl/pisp_ram.sv -----
// Generic single-port RAM with registered read.
module pisp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ----- rtl/pi_sine_pwm_inverter_control.sv -----
// Top level: PI-regulated sinusoidal PWM control, one tick item in, one result out.
//
// Input channel s_valid/s_ready/s_data carries one tick: ADC sample and two switches.
// Result channel m_valid/m_ready/m_data returns compares, drive enable, trip flag, LEDs.
// Config channel cfg_valid/cfg_ready/cfg_index/cfg_data writes the five loop registers;
// it is always ready; write it only while the block is idle, which the block does not enforce.
// A trip tick or a non-run tick goes straight from idle to the result load; a run tick
// passes through ring read, sum update, error, three passes through the one shared
// signed 19x17 multiplier, compare build and result load. One item at a time: s_ready
// is high only in the idle state, so a new item is taken only after the last one is loaded.
// The ring lives in a 256-entry RAM; a valid bit per entry makes unwritten entries
// read as zero, so reset and a non-run tick clear the ring at once, with no sweep.
// Reset clears the loop state, loads the default registers, sets both compare
// holds to 1500 and clears the trip latch and LEDs.
// A finished result waits in the output register; while the receiver stalls the
// block may take the next item, but holds its new result until the old one goes.
module pi_sine_pwm_inverter_control (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  pisp_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output pisp_pkg::out_t m_data,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [2:0]     cfg_index,
    input  logic [15:0]    cfg_data
);
    import pisp_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_READ, ST_SUM, ST_ERR, ST_IMUL, ST_INTEG, ST_TOTAL, ST_SMUL,
        ST_CMP, ST_DONE
    } state_t;

    state_t state_reg;

    logic [15:0] setpoint_reg, prop_reg, igain_reg;
    logic [11:0] trip_lvl_reg;
    logic [14:0] period_reg;

    logic [SAMPLE_BITS-1:0]       sample_reg;
    logic [RING_DEPTH-1:0]        valid_reg;
    logic [SUM_BITS-1:0]          sum_reg;
    logic [PH_BITS-1:0]           phase_reg;
    logic signed [ERR_BITS-1:0]   err_reg, prev_reg;
    logic signed [INTEG_BITS-1:0] integ_reg;
    logic [13:0]                  out_reg;
    logic [14:0]                  hold1_reg, hold2_reg;
    logic                         trip_reg, drive_reg;
    logic [1:0]                   led_reg;
    logic signed [PROD_BITS-1:0]  prod_reg;
    out_t                         m_data_reg;
    logic                         m_valid_reg;

    logic [SAMPLE_BITS-1:0] ram_rdata;
    logic                   ram_we;
    logic [13:0]            half;
    logic [SAMPLE_BITS-1:0] old_sample;
    logic signed [MULA_BITS-1:0] mul_a;
    logic signed [MULB_BITS-1:0] mul_b;
    logic signed [SUM_BITS+4:0]  avg16;
    logic signed [PROD_BITS:0]   half_q;
    logic signed [PROD_BITS-1:0] istep;
    logic signed [INTEG_BITS:0]  integ_sum, total;
    logic [INTEG_BITS-21:0]      o_raw;
    logic signed [17:0]          s_val, c1, c2;
    logic                        trip_hit;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign half      = period_reg[14:1];
    assign ram_we    = (state_reg == ST_SUM);
    assign old_sample = valid_reg[phase_reg] ? ram_rdata : '0;
    assign trip_hit  = trip_reg || ({4'd0, s_data.adc_sample} >= {4'd0, trip_lvl_reg});

    pisp_ram #(
        .WIDTH(SAMPLE_BITS),
        .DEPTH(RING_DEPTH)
    ) u_ring (
        .aclk (aclk),
        .we   (ram_we),
        .addr (phase_reg),
        .wdata(sample_reg),
        .rdata(ram_rdata)
    );

    // Select operands of the shared multiplier
    always_comb begin
        case (state_reg)
            ST_IMUL: begin
                mul_a = MULA_BITS'(err_reg) + MULA_BITS'(prev_reg);
                mul_b = MULB_BITS'({1'b0, igain_reg});
            end
            ST_INTEG: begin
                mul_a = MULA_BITS'(err_reg);
                mul_b = MULB_BITS'({1'b0, prop_reg});
            end
            ST_SMUL: begin
                mul_a = MULA_BITS'({1'b0, out_reg});
                mul_b = MULB_BITS'(sine_at(sine_index(phase_reg)));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Loop arithmetic around the product register
    always_comb begin
        avg16  = $signed({1'b0, sum_reg[SUM_BITS-1:PH_BITS], 4'd0, {PH_BITS{1'b0}}})
                 >>> PH_BITS;
        half_q = $signed((PROD_BITS+1)'({half, 20'd0}));
        if ($signed({prod_reg[PROD_BITS-1], prod_reg}) > half_q) begin
            istep = PROD_BITS'(half_q);
        end else if ($signed({prod_reg[PROD_BITS-1], prod_reg}) < -half_q) begin
            istep = PROD_BITS'(-half_q);
        end else begin
            istep = prod_reg;
        end
        integ_sum = $signed({integ_reg[INTEG_BITS-1], integ_reg})
                    + (INTEG_BITS+1)'(istep);
        total     = $signed({integ_reg[INTEG_BITS-1], integ_reg})
                    + (INTEG_BITS+1)'(prod_reg);
        o_raw     = total[INTEG_BITS-1:20];
        s_val     = 18'(prod_reg >>> SINE_SHIFT);
        c1        = $signed({3'd0, period_reg}) - $signed({4'd0, half}) - s_val;
        c2        = $signed({3'd0, period_reg}) - $signed({4'd0, half}) + s_val;
    end

    // Hold configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            setpoint_reg <= SETPOINT_RST;
            prop_reg     <= PROP_RST;
            igain_reg    <= INT_RST;
            trip_lvl_reg <= TRIP_RST;
            period_reg   <= PERIOD_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_SETPOINT: setpoint_reg <= cfg_data;
                REG_PROP:     prop_reg     <= cfg_data;
                REG_INT:      igain_reg    <= cfg_data;
                REG_TRIP:     trip_lvl_reg <= cfg_data[11:0];
                REG_PERIOD:   period_reg   <= cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // Sequence one tick through the shared multiplier
    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            valid_reg   <= '0;
            sum_reg     <= '0;
            phase_reg   <= '0;
            err_reg     <= '0;
            prev_reg    <= '0;
            integ_reg   <= '0;
            out_reg     <= '0;
            hold1_reg   <= HOLD_RST;
            hold2_reg   <= HOLD_RST;
            trip_reg    <= 1'b0;
            drive_reg   <= 1'b0;
            led_reg     <= 2'b00;
            sample_reg  <= '0;
            m_valid_reg <= 1'b0;
            m_data_reg  <= '0;
        end else begin
            // Drop the result after its transfer; the done state reloads it itself
            if (m_valid_reg && m_ready && state_reg != ST_DONE) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        sample_reg <= s_data.adc_sample;
                        drive_reg  <= 1'b0;
                        trip_reg   <= trip_hit;
                        if (trip_hit) begin
                            state_reg <= ST_DONE;
                        end else begin
                            led_reg <= {s_data.adc_switch, s_data.pwm_switch};
                            if (s_data.adc_switch && s_data.pwm_switch) begin
                                state_reg <= ST_READ;
                            end else begin
                                valid_reg <= '0;
                                sum_reg   <= '0;
                                prev_reg  <= '0;
                                integ_reg <= '0;
                                state_reg <= ST_DONE;
                            end
                        end
                    end
                end
                ST_READ: begin
                    state_reg <= ST_SUM;
                end
                ST_SUM: begin
                    sum_reg <= sum_reg - SUM_BITS'(old_sample) + SUM_BITS'(sample_reg);
                    valid_reg[phase_reg] <= 1'b1;
                    state_reg <= ST_ERR;
                end
                ST_ERR: begin
                    err_reg   <= ERR_BITS'($signed({1'b0, setpoint_reg}) - avg16);
                    state_reg <= ST_IMUL;
                end
                ST_IMUL: begin
                    state_reg <= ST_INTEG;
                end
                ST_INTEG: begin
                    // Saturate the integrator to 48 bits
                    if (integ_sum[INTEG_BITS] != integ_sum[INTEG_BITS-1]) begin
                        integ_reg <= integ_sum[INTEG_BITS] ?
                                     {1'b1, {(INTEG_BITS-1){1'b0}}} :
                                     {1'b0, {(INTEG_BITS-1){1'b1}}};
                    end else begin
                        integ_reg <= integ_sum[INTEG_BITS-1:0];
                    end
                    prev_reg  <= err_reg;
                    state_reg <= ST_TOTAL;
                end
                ST_TOTAL: begin
                    if (total[INTEG_BITS] || (o_raw == '0)) begin
                        out_reg <= '0;
                    end else if (o_raw > (INTEG_BITS-20)'(half)) begin
                        out_reg <= half;
                    end else begin
                        out_reg <= o_raw[13:0];
                    end
                    state_reg <= ST_SMUL;
                end
                ST_SMUL: begin
                    state_reg <= ST_CMP;
                end
                ST_CMP: begin
                    hold1_reg <= c1[17] ? 15'd0 : (c1 > 18'sd32767 ? 15'h7FFF : c1[14:0]);
                    hold2_reg <= c2[17] ? 15'd0 : (c2 > 18'sd32767 ? 15'h7FFF : c2[14:0]);
                    drive_reg <= 1'b1;
                    phase_reg <= phase_reg + 1'b1;
                    state_reg <= ST_DONE;
                end
                ST_DONE: begin
                    // Load the result once the output register is free
                    if (!m_valid_reg || m_ready) begin
                        m_data_reg.compare_one  <= hold1_reg;
                        m_data_reg.compare_two  <= hold2_reg;
                        m_data_reg.drive_enable <= drive_reg;
                        m_data_reg.tripped      <= trip_reg;
                        m_data_reg.led_measure  <= led_reg[1];
                        m_data_reg.led_drive    <= led_reg[0];
                        m_valid_reg             <= 1'b1;
                        state_reg               <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Trip latch never releases without reset
    a_trip_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        trip_reg |=> trip_reg)
        else $error("trip latch released");

    // A driving result is never a tripped one
    a_drive_not_tripped: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.drive_enable |-> !m_data.tripped)
        else $error("drive enabled while tripped");

    // Driving implies both switches were on
    a_drive_leds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.drive_enable |-> m_data.led_measure && m_data.led_drive)
        else $error("drive enabled without both switches");

endmodule
